// ----- src/gmdc_pkg.sv -----
// Shared types, codes and constants for the gate motor direction controller.
`timescale 1ns / 1ps
package gmdc_pkg;

	// Age counter width and derived limits
	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [CMP_W-1:0]      cmp_t;
	typedef logic [CFG_W-1:0]      cfg_word_t;

	localparam timer_t TMAX = {TIMER_BITS{1'b1}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STOP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_REVERSE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_MIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_MAX     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_CUR     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_ACTIVE = 3'd6;

	// Command codes
	localparam logic [2:0] CMD_NONE       = 3'd0;
	localparam logic [2:0] CMD_OPEN       = 3'd1;
	localparam logic [2:0] CMD_CLOSE      = 3'd2;
	localparam logic [2:0] CMD_STOP       = 3'd3;
	localparam logic [2:0] CMD_TEST_OPEN  = 3'd4;
	localparam logic [2:0] CMD_TEST_CLOSE = 3'd5;
	localparam logic [2:0] CMD_TEST_STOP  = 3'd6;
	localparam logic [2:0] CMD_OBSTACLE   = 3'd7;

	// Request status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TOO_SOON   = 3'd1;
	localparam logic [2:0] ST_REV_FAST   = 3'd2;
	localparam logic [2:0] ST_AT_LIMIT   = 3'd3;
	localparam logic [2:0] ST_BUTTON     = 3'd4;

	// Motion output codes
	localparam logic [1:0] MOT_IDLE    = 2'd0;
	localparam logic [1:0] MOT_OPENING = 2'd1;
	localparam logic [1:0] MOT_CLOSING = 2'd2;
	localparam logic [1:0] MOT_BACKOFF = 2'd3;

	// Position output codes
	localparam logic [1:0] POS_OPEN   = 2'd0;
	localparam logic [1:0] POS_CLOSED = 2'd1;
	localparam logic [1:0] POS_MIDDLE = 2'd2;

	// Motion state, one-hot
	typedef enum logic [3:0] {
		MS_IDLE    = 4'b0001,
		MS_OPENING = 4'b0010,
		MS_CLOSING = 4'b0100,
		MS_BACKOFF = 4'b1000
	} mstate_t;

	typedef struct packed {
		cfg_word_t min_stop_ms;
		cfg_word_t min_reverse_ms;
		cfg_word_t debounce_ms;
		cfg_word_t start_min_ms;
		cfg_word_t start_max_ms;
		cfg_word_t start_current_limit;
		logic      button_active_level;
	} cfg_t;

	typedef struct packed {
		mstate_t motion_state;
		logic    last_dir_open;
		timer_t  since_stop_ms;
		timer_t  since_dir_change_ms;
		logic    button_prev;
		logic    button_stable;
		timer_t  button_age_ms;
		logic    start_active;
		logic    start_finished;
		timer_t  start_age_ms;
		logic    drv_main;
		logic    drv_rev;
		logic    drv_start;
	} gate_state_t;

	typedef struct packed {
		logic [15:0] motor_current_ma;
		logic        closed_limit;
		logic        open_limit;
		logic        button_level;
		logic        obstacle_while_opening;
		logic [2:0]  command;
	} tick_t;

	typedef struct packed {
		logic [1:0] position;
		logic [2:0] request_status;
		logic [1:0] motion;
		logic       lamp_on;
		logic       start_relay_on;
		logic       reverse_relay_on;
		logic       main_switch_on;
	} result_t;

	function automatic timer_t sat_inc(timer_t x);
		return (x == TMAX) ? x : x + timer_t'(1);
	endfunction

	function automatic logic [1:0] motion_code(mstate_t m);
		logic [1:0] code;
		unique case (m)
			MS_OPENING: code = MOT_OPENING;
			MS_CLOSING: code = MOT_CLOSING;
			MS_BACKOFF: code = MOT_BACKOFF;
			default:    code = MOT_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ----- src/gmdc_core.sv -----
// Per-tick next-state and result logic of the gate motor controller.
`timescale 1ns / 1ps
module gmdc_core import gmdc_pkg::*; (
	input  cfg_t        cfg,
	input  gate_state_t cur,
	input  tick_t       tick,
	output gate_state_t nxt,
	output result_t     res
);

	always_comb begin
		gate_state_t s;
		logic [2:0]  status;
		logic [2:0]  r;
		logic        dir;
		logic        fire;
		logic        refuse_limit;

		s      = cur;
		status = ST_OK;
		r      = ST_OK;
		dir    = 1'b0;
		fire   = 1'b0;
		refuse_limit = 1'b0;

		// Advance all age counters
		s.since_stop_ms       = sat_inc(s.since_stop_ms);
		s.since_dir_change_ms = sat_inc(s.since_dir_change_ms);
		s.button_age_ms       = sat_inc(s.button_age_ms);
		s.start_age_ms        = sat_inc(s.start_age_ms);

		// Apply the command
		unique case (tick.command)
			CMD_OPEN, CMD_CLOSE: begin
				dir = (tick.command == CMD_OPEN);
				refuse_limit = dir ? tick.open_limit : tick.closed_limit;
				if (cmp_t'(s.since_stop_ms) < cmp_t'(cfg.min_stop_ms)) begin
					status = ST_TOO_SOON;
				end else if (cmp_t'(s.since_dir_change_ms) < cmp_t'(cfg.min_reverse_ms)) begin
					status = ST_REV_FAST;
				end else if (s.motion_state == MS_IDLE && refuse_limit) begin
					status = ST_AT_LIMIT;
				end else begin
					s.drv_main = 1'b1;
					s.drv_rev = !dir;
					s.drv_start = 1'b0;
					s.motion_state = dir ? MS_OPENING : MS_CLOSING;
					s.last_dir_open = dir;
					s.since_stop_ms = '0;
					s.start_active = 1'b0;
					s.start_finished = 1'b0;
					s.since_dir_change_ms = '0;
				end
			end
			CMD_STOP, CMD_TEST_STOP: begin
				s.drv_main = 1'b0;
				s.drv_rev = 1'b0;
				s.drv_start = 1'b0;
				s.motion_state = MS_IDLE;
				s.since_stop_ms = '0;
				s.start_active = 1'b0;
				s.start_finished = 1'b0;
			end
			CMD_TEST_OPEN, CMD_TEST_CLOSE: begin
				dir = (tick.command == CMD_TEST_OPEN);
				s.drv_main = 1'b1;
				s.drv_rev = !dir;
				s.drv_start = 1'b0;
				s.motion_state = dir ? MS_OPENING : MS_CLOSING;
				s.last_dir_open = dir;
				s.since_stop_ms = '0;
				s.start_active = 1'b0;
				s.start_finished = 1'b0;
			end
			CMD_OBSTACLE: begin
				s.drv_main = 1'b1;
				s.drv_rev = tick.obstacle_while_opening;
				s.drv_start = 1'b0;
				s.last_dir_open = !tick.obstacle_while_opening;
				s.motion_state = MS_BACKOFF;
				s.start_active = 1'b0;
				s.start_finished = 1'b0;
				s.since_dir_change_ms = '0;
				s.since_stop_ms = (cmp_t'(cfg.min_stop_ms) < cmp_t'(TMAX)) ?
					timer_t'(cfg.min_stop_ms) : TMAX;
			end
			default: begin
			end
		endcase

		// Debounce the button and act on a press
		if (tick.button_level != s.button_prev)
			s.button_age_ms = '0;
		if (cmp_t'(s.button_age_ms) > cmp_t'(cfg.debounce_ms) &&
		    tick.button_level != s.button_stable) begin
			s.button_stable = tick.button_level;
			fire = (tick.button_level == cfg.button_active_level);
		end
		if (fire) begin
			if (s.motion_state != MS_IDLE) begin
				s.drv_main = 1'b0;
				s.drv_rev = 1'b0;
				s.drv_start = 1'b0;
				s.motion_state = MS_IDLE;
				s.since_stop_ms = '0;
				s.start_active = 1'b0;
				s.start_finished = 1'b0;
			end else begin
				dir = s.last_dir_open ? tick.closed_limit : !tick.open_limit;
				refuse_limit = dir ? tick.open_limit : tick.closed_limit;
				if (cmp_t'(s.since_stop_ms) < cmp_t'(cfg.min_stop_ms)) begin
					r = ST_TOO_SOON;
				end else if (cmp_t'(s.since_dir_change_ms) < cmp_t'(cfg.min_reverse_ms)) begin
					r = ST_REV_FAST;
				end else if (refuse_limit) begin
					r = ST_AT_LIMIT;
				end else begin
					s.drv_main = 1'b1;
					s.drv_rev = !dir;
					s.drv_start = 1'b0;
					s.motion_state = dir ? MS_OPENING : MS_CLOSING;
					s.last_dir_open = dir;
					s.since_stop_ms = '0;
					s.start_active = 1'b0;
					s.start_finished = 1'b0;
					s.since_dir_change_ms = '0;
				end
			end
			status = (r != ST_OK) ? r : ST_BUTTON;
		end
		s.button_prev = tick.button_level;

		// Hold or release the start relay
		if (s.motion_state == MS_OPENING || s.motion_state == MS_CLOSING) begin
			if (!s.start_active && !s.start_finished) begin
				s.start_active = 1'b1;
				s.start_age_ms = '0;
				s.drv_start = 1'b1;
			end else if (s.start_active) begin
				if ((tick.motor_current_ma < cfg.start_current_limit &&
				     cmp_t'(s.start_age_ms) > cmp_t'(cfg.start_min_ms)) ||
				    cmp_t'(s.start_age_ms) > cmp_t'(cfg.start_max_ms)) begin
					s.start_active = 1'b0;
					s.start_finished = 1'b1;
					s.drv_start = 1'b0;
				end
			end
		end else begin
			s.start_active = 1'b0;
			s.start_finished = 1'b0;
			s.drv_start = 1'b0;
		end

		nxt = s;

		// Form the result beat
		res.main_switch_on   = s.drv_main;
		res.reverse_relay_on = s.drv_rev;
		res.start_relay_on   = s.drv_start;
		res.lamp_on          = (s.motion_state != MS_IDLE);
		res.motion           = motion_code(s.motion_state);
		res.request_status   = status;
		if (tick.open_limit && !tick.closed_limit)
			res.position = POS_OPEN;
		else if (!tick.open_limit && tick.closed_limit)
			res.position = POS_CLOSED;
		else
			res.position = POS_MIDDLE;
	end

endmodule

// ----- src/gate_motor_direction_controller.sv -----
// Top level of the gate motor direction controller: handshake, config and state.
//
// Usage: each input beat on the s_ channel is one millisecond tick. s_tuser
// carries the command code; s_tdata carries obstacle direction, button level,
// the two limit switches and the motor current sample. Every tick yields
// exactly one result beat on the m_ channel with the relay drives, lamp,
// motion code, request status and limit-switch position.
// A tick is taken into the input register, evaluated combinationally and
// placed in the result register. Throughput: one tick per cycle while the
// receiver takes result beats. Configuration, via cfg_we/cfg_idx/cfg_data,
// is the user's to write only while idle; the block does not enforce this.
// Reset (arst_n low) idles the gate, drops all drives, saturates the stop and
// direction ages and loads the default configuration.
// A stalled receiver holds the result beat in place; one more tick may sit in
// the input register, after which s_tready falls until m_tready returns.
`timescale 1ns / 1ps
module gate_motor_direction_controller import gmdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] obstacle_while_opening, [1] button_level, [2] open_limit,
	// [3] closed_limit, [19:4] motor_current_ma, [23:20] zero
	input  logic [23:0]          s_tdata,
	// [2:0] command
	input  logic [2:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] main_switch_on, [1] reverse_relay_on, [2] start_relay_on, [3] lamp_on,
	// [5:4] motion, [8:6] request_status, [10:9] position, [15:11] zero
	output logic [15:0]          m_tdata
);

	cfg_t        cfg_q;
	gate_state_t state_q;
	gate_state_t state_nxt;
	tick_t       tick_s1;
	logic        valid_s1;
	result_t     res_nxt;
	result_t     res_q;
	logic        out_valid_q;
	logic        out_free;
	logic        adv;

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_stop_ms         <= 16'd300;
			cfg_q.min_reverse_ms      <= 16'd800;
			cfg_q.debounce_ms         <= 16'd100;
			cfg_q.start_min_ms        <= 16'd1000;
			cfg_q.start_max_ms        <= 16'd3000;
			cfg_q.start_current_limit <= 16'd2000;
			cfg_q.button_active_level <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_STOP:      cfg_q.min_stop_ms         <= cfg_data;
				REG_MIN_REVERSE:   cfg_q.min_reverse_ms      <= cfg_data;
				REG_DEBOUNCE:      cfg_q.debounce_ms         <= cfg_data;
				REG_START_MIN:     cfg_q.start_min_ms        <= cfg_data;
				REG_START_MAX:     cfg_q.start_max_ms        <= cfg_data;
				REG_START_CUR:     cfg_q.start_current_limit <= cfg_data;
				REG_BUTTON_ACTIVE: cfg_q.button_active_level <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1.command                <= s_tuser;
			tick_s1.obstacle_while_opening <= s_tdata[0];
			tick_s1.button_level           <= s_tdata[1];
			tick_s1.open_limit             <= s_tdata[2];
			tick_s1.closed_limit           <= s_tdata[3];
			tick_s1.motor_current_ma       <= s_tdata[19:4];
		end
	end

	gmdc_core u_core (
		.cfg  (cfg_q),
		.cur  (state_q),
		.tick (tick_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Advance the controller state once per evaluated tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.motion_state        <= MS_IDLE;
			state_q.last_dir_open       <= 1'b1;
			state_q.since_stop_ms       <= TMAX;
			state_q.since_dir_change_ms <= TMAX;
			state_q.button_prev         <= 1'b1;
			state_q.button_stable       <= 1'b1;
			state_q.button_age_ms       <= '0;
			state_q.start_active        <= 1'b0;
			state_q.start_finished      <= 1'b0;
			state_q.start_age_ms        <= '0;
			state_q.drv_main            <= 1'b0;
			state_q.drv_rev             <= 1'b0;
			state_q.drv_start           <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q.position, res_q.request_status, res_q.motion,
		res_q.lamp_on, res_q.start_relay_on, res_q.reverse_relay_on,
		res_q.main_switch_on};

endmodule
